>>> hw/rtl/gprm_pkg.sv
// ----------------------------------------------------------------------------
// gprm_pkg: shared definitions of the gated pulse-rate meter
// Register map, reset values, display constants and digit decode functions.
// ----------------------------------------------------------------------------
package gprm_pkg;

	localparam int COUNT_WIDTH_DEF = 8;

	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 3;
	localparam int SCALE_W = 4;

	// register indexes
	localparam logic [IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [IDX_W-1:0] REG_WARMUP   = 3'd1;
	localparam logic [IDX_W-1:0] REG_GATE     = 3'd2;
	localparam logic [IDX_W-1:0] REG_SCALE    = 3'd3;
	localparam logic [IDX_W-1:0] REG_REFRESH  = 3'd4;
	localparam logic [IDX_W-1:0] REG_STARTUP  = 3'd5;
	localparam logic [IDX_W-1:0] REG_RESULT   = 3'd6;

	// reset values
	localparam logic [9:0]  DEBOUNCE_RST = 10'd300;
	localparam logic [9:0]  WARMUP_RST   = 10'd600;
	localparam logic [15:0] GATE_RST     = 16'd15000;
	localparam logic [3:0]  SCALE_RST    = 4'd4;
	localparam logic [7:0]  REFRESH_RST  = 8'd5;
	localparam logic [9:0]  STARTUP_RST  = 10'd181;
	localparam logic [9:0]  RESULT_RST   = 10'd541;

	localparam logic [9:0] RATE_MAX     = 10'd999;
	localparam logic [6:0] BLANK_SEGS   = 7'h7F;
	localparam logic [2:0] BLANK_DIGITS = 3'h7;

	localparam int RES_W = 22;
	localparam int OUT_W = 24;
	localparam int IN_W  = 8;

	typedef struct packed {
		logic [9:0]  debounce_ticks;
		logic [9:0]  warmup_ticks;
		logic [15:0] gate_ticks;
		logic [3:0]  rate_scale;
		logic [7:0]  refresh_ticks;
		logic [9:0]  startup_frames;
		logic [9:0]  result_frames;
	} cfg_t;

	// one decimal digit of a value below 1000; pos 0 ones, 1 tens, 2 hundreds
	function automatic logic [3:0] digit_of(input logic [9:0] v, input logic [1:0] pos);
		logic [3:0]  hund;
		logic [9:0]  rem;
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		hund = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (v >= 10'(k * 100))
				hund = 4'(k);
		end
		rem  = v - 10'(hund) * 10'd100;
		prod = 15'(rem[6:0]) * 15'd205;
		tens = prod[14:11];
		ones = rem[6:0] - 7'(tens) * 7'd10;
		case (pos)
			2'd0:    digit_of = ones[3:0];
			2'd1:    digit_of = tens;
			default: digit_of = hund;
		endcase
	endfunction

	// active-low pattern g..a
	function automatic logic [6:0] seg_of(input logic [3:0] d);
		case (d)
			4'd0:    seg_of = 7'h40;
			4'd1:    seg_of = 7'h79;
			4'd2:    seg_of = 7'h24;
			4'd3:    seg_of = 7'h30;
			4'd4:    seg_of = 7'h19;
			4'd5:    seg_of = 7'h12;
			4'd6:    seg_of = 7'h02;
			4'd7:    seg_of = 7'h78;
			4'd8:    seg_of = 7'h00;
			4'd9:    seg_of = 7'h10;
			default: seg_of = BLANK_SEGS;
		endcase
	endfunction

	function automatic logic [2:0] enable_of(input logic [1:0] pos);
		case (pos)
			2'd0:    enable_of = 3'h6;
			2'd1:    enable_of = 3'h5;
			default: enable_of = 3'h3;
		endcase
	endfunction

endpackage

>>> hw/rtl/gated_pulse_rate_meter.sv
// ----------------------------------------------------------------------------
// gated_pulse_rate_meter: tick-driven gated pulse-rate meter
// Input register, one-tick sequencer step and result register, with APB config.
// ----------------------------------------------------------------------------
// A tick request waits in the input register until the sequencer steps on it.
// Throughput: one tick per cycle unless the output stalls; the result register
// takes a new result as the old one is taken, so stalls only hold the pipeline.
// Reset: clears the pipeline, starts the startup display with a rate of zero
// and loads every configuration register with its default.
module gated_pulse_rate_meter #(
	parameter int COUNT_WIDTH = gprm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [gprm_pkg::IN_W-1:0]    s_tdata,   // button_pressed, pulse_edge
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// segments[6:0], digit_enable[9:7], emitter_on[10], busy_res[11], rate[21:12]
	output logic [gprm_pkg::OUT_W-1:0]   m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gprm_pkg::ADDR_W-1:0]  paddr,
	input  logic [gprm_pkg::DATA_W-1:0]  pwdata,
	output logic [gprm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import gprm_pkg::*;

	cfg_t             cfg;
	logic             valid_s1, press_s1, pulse_s1;
	logic             out_valid_q;
	logic [RES_W-1:0] out_data_q;
	logic [RES_W-1:0] result;
	logic             advance;

	assign pready   = 1'b1;
	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - RES_W){1'b0}}, out_data_q};

	gprm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	gprm_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.press  (press_s1),
		.pulse  (pulse_s1),
		.result (result)
	);

	// input register: hold the request until the sequencer steps on it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			press_s1 <= s_tdata[0];
			pulse_s1 <= s_tdata[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data_q <= result;
	end

endmodule

>>> hw/rtl/gprm_regs.sv
// ----------------------------------------------------------------------------
// gprm_regs: configuration register file
// APB-style write and read of the seven timing and scale registers.
// ----------------------------------------------------------------------------
module gprm_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gprm_pkg::ADDR_W-1:0]  paddr,
	input  logic [gprm_pkg::DATA_W-1:0]  pwdata,
	output logic [gprm_pkg::DATA_W-1:0]  prdata,
	output gprm_pkg::cfg_t               cfg
);
	import gprm_pkg::*;

	cfg_t             cfg_q;
	logic             wr;
	logic [IDX_W-1:0] idx;

	assign idx = paddr[ADDR_W-1:2];
	assign wr  = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DEBOUNCE_RST;
			cfg_q.warmup_ticks   <= WARMUP_RST;
			cfg_q.gate_ticks     <= GATE_RST;
			cfg_q.rate_scale     <= SCALE_RST;
			cfg_q.refresh_ticks  <= REFRESH_RST;
			cfg_q.startup_frames <= STARTUP_RST;
			cfg_q.result_frames  <= RESULT_RST;
		end else if (wr) begin
			case (idx)
				REG_DEBOUNCE: cfg_q.debounce_ticks <= pwdata[9:0];
				REG_WARMUP:   cfg_q.warmup_ticks   <= pwdata[9:0];
				REG_GATE:     cfg_q.gate_ticks     <= pwdata[15:0];
				REG_SCALE:    cfg_q.rate_scale     <= pwdata[3:0];
				REG_REFRESH:  cfg_q.refresh_ticks  <= pwdata[7:0];
				REG_STARTUP:  cfg_q.startup_frames <= pwdata[9:0];
				REG_RESULT:   cfg_q.result_frames  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DEBOUNCE: prdata = DATA_W'(cfg_q.debounce_ticks);
			REG_WARMUP:   prdata = DATA_W'(cfg_q.warmup_ticks);
			REG_GATE:     prdata = DATA_W'(cfg_q.gate_ticks);
			REG_SCALE:    prdata = DATA_W'(cfg_q.rate_scale);
			REG_REFRESH:  prdata = DATA_W'(cfg_q.refresh_ticks);
			REG_STARTUP:  prdata = DATA_W'(cfg_q.startup_frames);
			REG_RESULT:   prdata = DATA_W'(cfg_q.result_frames);
			default:      prdata = '0;
		endcase
	end

endmodule

>>> hw/rtl/gprm_core.sv
// ----------------------------------------------------------------------------
// gprm_core: phase sequencer, gate counter and display scan
// Advances the measurement state by one tick per step and forms the result.
// ----------------------------------------------------------------------------
module gprm_core #(
	parameter int COUNT_WIDTH = gprm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gprm_pkg::cfg_t              cfg,
	input  logic                        step,
	input  logic                        press,
	input  logic                        pulse,
	output logic [gprm_pkg::RES_W-1:0]  result
);
	import gprm_pkg::*;

	localparam int PROD_W = COUNT_WIDTH + SCALE_W;

	localparam logic [2:0] PH_STARTUP  = 3'd0;
	localparam logic [2:0] PH_IDLE     = 3'd1;
	localparam logic [2:0] PH_DEBOUNCE = 3'd2;
	localparam logic [2:0] PH_WARMUP   = 3'd3;
	localparam logic [2:0] PH_GATE     = 3'd4;
	localparam logic [2:0] PH_RESULT   = 3'd5;

	logic [2:0]             phase_q, ph;
	logic [15:0]            timer_q, tmr;
	logic [COUNT_WIDTH-1:0] count_q, cnt;
	logic [9:0]             rate_q, rv;
	logic [9:0]             frame_q, fc, frames;
	logic [1:0]             digit_q, di, pos;
	logic [7:0]             refresh_q, rt;
	logic [8:0]             rt_inc;
	logic [PROD_W-1:0]      prod;
	logic [6:0]             segs;
	logic [2:0]             dig;
	logic                   emit, busy;

	always_comb begin
		ph     = (phase_q > PH_RESULT) ? PH_IDLE : phase_q;
		tmr    = timer_q;
		cnt    = count_q;
		rv     = rate_q;
		fc     = frame_q;
		di     = digit_q;
		rt     = refresh_q;
		segs   = BLANK_SEGS;
		dig    = BLANK_DIGITS;
		emit   = 1'b0;
		busy   = 1'b1;
		frames = cfg.result_frames;
		pos    = 2'd0;
		rt_inc = 9'd0;
		prod   = '0;

		// leave waits that have run out, falling through zero-length phases
		if (ph == PH_DEBOUNCE && tmr >= {6'd0, cfg.debounce_ticks}) begin
			ph  = PH_WARMUP;
			tmr = '0;
		end
		if (ph == PH_WARMUP && tmr >= {6'd0, cfg.warmup_ticks}) begin
			ph  = PH_GATE;
			tmr = '0;
			cnt = '0;
		end
		if (ph == PH_GATE && tmr >= cfg.gate_ticks) begin
			prod = PROD_W'(cnt) * PROD_W'(cfg.rate_scale);
			if ({10'd0, prod} > (PROD_W + 10)'(RATE_MAX))
				rv = RATE_MAX;
			else
				rv = 10'(prod);
			ph = PH_RESULT;
			fc = '0;
			di = '0;
			rt = '0;
		end
		if (ph == PH_STARTUP && fc >= cfg.startup_frames)
			ph = PH_IDLE;
		if (ph == PH_RESULT && fc >= cfg.result_frames)
			ph = PH_IDLE;

		case (ph)
			PH_IDLE: begin
				busy = 1'b0;
				if (press) begin
					ph  = PH_DEBOUNCE;
					tmr = '0;
				end
			end
			PH_DEBOUNCE: begin
				tmr = tmr + 16'd1;
			end
			PH_WARMUP: begin
				emit = 1'b1;
				tmr  = tmr + 16'd1;
			end
			PH_GATE: begin
				emit = 1'b1;
				if (pulse && cnt != '1)
					cnt = cnt + 1'b1;
				tmr = tmr + 16'd1;
			end
			default: begin
				frames = (ph == PH_STARTUP) ? cfg.startup_frames : cfg.result_frames;
				pos    = (di > 2'd2) ? 2'd0 : di;
				segs   = seg_of(digit_of(rv, pos));
				dig    = enable_of(pos);
				rt_inc = {1'b0, rt} + 9'd1;
				// a zero refresh length behaves as one tick
				if (rt_inc >= {1'b0, cfg.refresh_ticks}) begin
					rt = '0;
					if (pos == 2'd2) begin
						di = '0;
						fc = fc + 10'd1;
						if (fc >= frames)
							ph = PH_IDLE;
					end else begin
						di = pos + 2'd1;
					end
				end else begin
					rt = rt_inc[7:0];
				end
			end
		endcase
	end

	assign result = {rv, busy, emit, dig, segs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_STARTUP;
			timer_q   <= '0;
			count_q   <= '0;
			rate_q    <= '0;
			frame_q   <= '0;
			digit_q   <= '0;
			refresh_q <= '0;
		end else if (step) begin
			phase_q   <= ph;
			timer_q   <= tmr;
			count_q   <= cnt;
			rate_q    <= rv;
			frame_q   <= fc;
			digit_q   <= di;
			refresh_q <= rt;
		end
	end

endmodule

>>> hw/rtl/gprm_checker.sv
// ----------------------------------------------------------------------------
// gprm_checker: port-level assertions of the pulse-rate meter
// Watches the result stream for display, emitter, rate and hold rules.
// ----------------------------------------------------------------------------
module gprm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	logic [6:0] segs;
	logic [2:0] dig;
	logic       emit, busy;
	logic [9:0] rate;

	assign segs = m_tdata[6:0];
	assign dig  = m_tdata[9:7];
	assign emit = m_tdata[10];
	assign busy = m_tdata[11];
	assign rate = m_tdata[21:12];

	// idle shows a dark display
	a_idle_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !busy |-> dig == 3'h7 && segs == 7'h7F)
		else $error("display lit while idle");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && emit |-> busy && dig == 3'h7)
		else $error("emitter on outside a measurement");

	a_rate_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> rate <= 10'd999)
		else $error("rate above saturation");

	// at most one digit driven at a time
	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot(~dig) || dig == 3'h7)
		else $error("several digits enabled");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind gated_pulse_rate_meter gprm_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
